FILE: src/sd4c_pkg.sv
`default_nettype none

package sd4c_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned EMIT_LEN  = 8;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_EMIT  = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    typedef logic [NUM_LANES-1:0][CRC_W-1:0] t_crc_arr;

    typedef struct packed {
        logic                 emit;
        t_crc_arr             crcs;
        logic [NUM_LANES-1:0] lanes_ok;
        logic                 crc_ok;
    } t_event;

    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                                 input logic b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-1){1'b0}}};
        return {c[CRC_W-2:0], 1'b0} ^ (c[CRC_W-1] ? CRC_POLY : '0);
    endfunction

    function automatic logic [7:0] emit_byte(input t_crc_arr crcs);
        logic [7:0] ob;
        for (int d = 0; d < NUM_LANES; d++) begin
            ob[4+d] = crcs[d][CRC_W-1];
            ob[d]   = crcs[d][CRC_W-2];
        end
        return ob;
    endfunction

    function automatic t_crc_arr shift_two(input t_crc_arr crcs);
        t_crc_arr s;
        for (int d = 0; d < NUM_LANES; d++) begin
            s[d] = {crcs[d][CRC_W-3:0], 2'b00};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/sd4c_if.sv
`default_nettype none

interface sd4c_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sd4c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       is_check_result;
    logic [3:0] lanes_ok;
    logic       crc_ok;

    modport source (output valid, output out_byte, output last_of_run,
                    output is_check_result, output lanes_ok, output crc_ok,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input is_check_result, input lanes_ok, input crc_ok,
                    output ready);
endinterface

`default_nettype wire

FILE: src/sd4c_lane_crc.sv
`default_nettype none

module sd4c_lane_crc (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    input  wire logic            i_fire,
    input  wire logic [1:0]      i_op,
    input  wire logic [7:0]      i_byte,
    output logic                 o_needs_out,
    output sd4c_pkg::t_event     o_evt
);
    import sd4c_pkg::*;

    t_crc_arr             r_lane_crc, n_lane_crc;
    t_crc_arr             r_rx_crc,   n_rx_crc;
    logic [2:0]           r_chk_cnt,  n_chk_cnt;
    logic                 r_four_line;
    t_crc_arr             data_crc;
    t_crc_arr             rx_shift;
    logic [NUM_LANES-1:0] need;
    logic [NUM_LANES-1:0] mask;
    logic                 final_chk;

    always_comb begin
        for (int d = 0; d < NUM_LANES; d++) begin
            data_crc[d] = crc_bit(crc_bit(r_lane_crc[d], i_byte[4+d]), i_byte[d]);
            rx_shift[d] = {r_rx_crc[d][CRC_W-3:0], i_byte[4+d], i_byte[d]};
            mask[d]     = (r_lane_crc[d] == rx_shift[d]);
        end
        need = r_four_line ? {NUM_LANES{1'b1}} : {{(NUM_LANES-1){1'b0}}, 1'b1};
    end

    assign final_chk   = (t_op'(i_op) == OP_CHECK) && (r_chk_cnt == 3'd7);
    assign o_needs_out = (t_op'(i_op) == OP_EMIT) || final_chk;

    assign o_evt.emit     = (t_op'(i_op) == OP_EMIT);
    assign o_evt.crcs     = r_lane_crc;
    assign o_evt.lanes_ok = mask & need;
    assign o_evt.crc_ok   = ((mask & need) == need);

    always_comb begin
        n_lane_crc = r_lane_crc;
        n_rx_crc   = r_rx_crc;
        n_chk_cnt  = r_chk_cnt;
        if (i_fire) begin
            case (t_op'(i_op))
                OP_DATA: begin
                    n_lane_crc = data_crc;
                end
                OP_EMIT: begin
                    n_lane_crc = '0;
                end
                OP_CHECK: begin
                    if (final_chk) begin
                        n_lane_crc = '0;
                        n_rx_crc   = '0;
                        n_chk_cnt  = '0;
                    end else begin
                        n_rx_crc  = rx_shift;
                        n_chk_cnt = r_chk_cnt + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_crc  <= '0;
            r_rx_crc    <= '0;
            r_chk_cnt   <= '0;
            r_four_line <= 1'b0;
        end else begin
            r_lane_crc <= n_lane_crc;
            r_rx_crc   <= n_rx_crc;
            r_chk_cnt  <= n_chk_cnt;
            if (i_cfg_we) begin
                r_four_line <= i_cfg_wdata;
            end
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && final_chk) |=> (r_chk_cnt == 3'd0 && r_rx_crc == '0 && r_lane_crc == '0))
        else $error("check result did not clear state");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && t_op'(i_op) == OP_EMIT) |=> (r_lane_crc == '0))
        else $error("emit did not clear lane crcs");

    a_one_line_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_four_line |-> (o_evt.lanes_ok[NUM_LANES-1:1] == '0))
        else $error("uncompared lane flagged in one-line mode");

endmodule

`default_nettype wire

FILE: src/sd4c_out_seq.sv
`default_nettype none

module sd4c_out_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_evt_valid,
    input  wire sd4c_pkg::t_event i_evt,
    output logic                 o_free,
    sd4c_out_if.source           o_out
);
    import sd4c_pkg::*;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_is_chk;
    logic [NUM_LANES-1:0] r_lanes_ok;
    logic                 r_crc_ok;
    t_crc_arr             r_buf;
    logic [2:0]           r_cnt;
    logic                 load;

    assign load   = !r_valid || o_out.ready;
    assign o_free = (r_cnt == 3'd0) && load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_evt_valid) begin
            r_valid <= 1'b1;
            r_cnt   <= i_evt.emit ? 3'(EMIT_LEN - 1) : 3'd0;
        end else if (load && r_cnt != 3'd0) begin
            r_valid <= 1'b1;
            r_cnt   <= r_cnt - 3'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt_valid) begin
            if (i_evt.emit) begin
                r_byte     <= emit_byte(i_evt.crcs);
                r_buf      <= shift_two(i_evt.crcs);
                r_last     <= 1'b0;
                r_is_chk   <= 1'b0;
                r_lanes_ok <= '0;
                r_crc_ok   <= 1'b0;
            end else begin
                r_byte     <= '0;
                r_last     <= 1'b1;
                r_is_chk   <= 1'b1;
                r_lanes_ok <= i_evt.lanes_ok;
                r_crc_ok   <= i_evt.crc_ok;
            end
        end else if (load && r_cnt != 3'd0) begin
            r_byte     <= emit_byte(r_buf);
            r_buf      <= shift_two(r_buf);
            r_last     <= (r_cnt == 3'd1);
            r_is_chk   <= 1'b0;
            r_lanes_ok <= '0;
            r_crc_ok   <= 1'b0;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.out_byte        = r_byte;
    assign o_out.last_of_run     = r_last;
    assign o_out.is_check_result = r_is_chk;
    assign o_out.lanes_ok        = r_lanes_ok;
    assign o_out.crc_ok          = r_crc_ok;

    a_cnt_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> r_valid)
        else $error("emission pending without a word held");

    a_evt_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid |-> o_free)
        else $error("event offered while sequencer busy");

    a_chk_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_is_chk) |-> (r_last && r_byte == 8'd0 && r_cnt == 3'd0))
        else $error("malformed check result word");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt_valid && i_evt.emit) |=> (r_cnt == 3'(EMIT_LEN - 1) && !r_last))
        else $error("emission did not start");

endmodule

`default_nettype wire

FILE: src/sd_dat4_crc16_engine_core.sv
// Channel   Dir  Payload                                              Handshake
// i_in      in   op[1:0], data_byte[7:0]                              valid/ready
// o_out     out  out_byte, last_of_run, is_check_result, lanes_ok,   valid/ready
//                crc_ok
// cfg       in   i_cfg_wdata (four_line_mode)                         i_cfg_we
//
// One word per cycle while no emit or final CRC word waits: a word enters the input
// register and, when it fires, updates the lane CRCs or loads the result register.
// An emit fills it with 8 words, one interleaved byte per cycle while o_out is ready;
// a later emit or final CRC word waits in the input register until the eighth leaves.
// Reset (i_rst_n low, synchronous) clears CRCs, received CRCs, count and mode.
// A stalled o_out holds only words that need a result slot; data words pass on.
`default_nettype none

module sd_dat4_crc16_engine_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    sd4c_in_if.sink    i_in,
    sd4c_out_if.source o_out
);
    import sd4c_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;
    logic       needs_out;
    logic       seq_free;
    logic       fire;
    t_event     evt;

    assign fire       = r_in_valid && (!needs_out || seq_free);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.op;
            r_in_byte <= i_in.data_byte;
        end
    end

    sd4c_lane_crc u_lane_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_op        (r_in_op),
        .i_byte      (r_in_byte),
        .o_needs_out (needs_out),
        .o_evt       (evt)
    );

    sd4c_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (fire && needs_out),
        .i_evt       (evt),
        .o_free      (seq_free),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: dv/sd_dat4_crc16_engine_core_tb.sv
`default_nettype none

module sd_dat4_crc16_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sd4c_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         SETTLE_TICKS = 16;
    localparam int         LONG_HOLD    = 300;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       is_check_result;
        logic [3:0] lanes_ok;
        logic       crc_ok;
    } t_crc_word;

    class crc_scoreboard;
        logic [CRC_W-1:0] lane_crc [NUM_LANES];
        logic [CRC_W-1:0] rx_crc [NUM_LANES];
        logic [2:0]       rx_count;
        logic             four_line;
        t_crc_word        pending [$];
        int               errors;

        function new();
            clear_all();
            four_line = 1'b0;
            errors = 0;
        endfunction

        function void clear_all();
            for (int d = 0; d < NUM_LANES; d++) begin
                lane_crc[d] = '0;
                rx_crc[d] = '0;
            end
            rx_count = '0;
        endfunction

        function void load_mode(logic m);
            four_line = m;
        endfunction

        function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic b);
            logic fb;
            fb = c[CRC_W-1] ^ b;
            return {c[CRC_W-2:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        endfunction

        function logic [7:0] crc_byte(int k);
            logic [7:0] ob;
            for (int d = 0; d < NUM_LANES; d++) begin
                ob[4+d] = lane_crc[d][15-2*k];
                ob[d]   = lane_crc[d][14-2*k];
            end
            return ob;
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] b);
            t_crc_word  r;
            logic [3:0] need;
            logic [3:0] mask;
            case (op)
                OP_DATA: begin
                    for (int d = 0; d < NUM_LANES; d++)
                        lane_crc[d] = crc_step(crc_step(lane_crc[d], b[4+d]), b[d]);
                end
                OP_EMIT: begin
                    for (int k = 0; k < EMIT_LEN; k++) begin
                        r = '0;
                        r.out_byte = crc_byte(k);
                        r.last_of_run = (k == EMIT_LEN - 1);
                        pending.push_back(r);
                    end
                    for (int d = 0; d < NUM_LANES; d++)
                        lane_crc[d] = '0;
                end
                OP_CHECK: begin
                    for (int d = 0; d < NUM_LANES; d++)
                        rx_crc[d] = {rx_crc[d][CRC_W-3:0], b[4+d], b[d]};
                    if (rx_count != 3'd7) begin
                        rx_count++;
                    end else begin
                        need = four_line ? 4'hF : 4'h1;
                        mask = '0;
                        for (int d = 0; d < NUM_LANES; d++)
                            mask[d] = (lane_crc[d] == rx_crc[d]);
                        mask &= need;
                        r = '0;
                        r.last_of_run = 1'b1;
                        r.is_check_result = 1'b1;
                        r.lanes_ok = mask;
                        r.crc_ok = (mask == need);
                        pending.push_back(r);
                        clear_all();
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_crc_word got);
            t_crc_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            compare_field("is_check_result", want.is_check_result, got.is_check_result);
            compare_field("lanes_ok", want.lanes_ok, got.lanes_ok);
            compare_field("crc_ok", want.crc_ok, got.crc_ok);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sd4c_in_if  in_if ();
    sd4c_out_if out_if ();

    sd_dat4_crc16_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    crc_scoreboard sb = new();

    int send_idle;
    int recv_stall;
    int hold_left;
    int items_sent;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin : rx_side
        t_crc_word got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.out_byte = out_if.out_byte;
            got.last_of_run = out_if.last_of_run;
            got.is_check_result = out_if.is_check_result;
            got.lanes_ok = out_if.lanes_ok;
            got.crc_ok = out_if.crc_ok;
            sb.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid <= 1'b0;
            in_if.op <= 2'($urandom);
            in_if.data_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_word(op, b);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.load_mode(m);
    endtask

    task automatic send_data_burst(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_word(OP_DATA, b);
        end
    endtask

    // align the received count first so the eight words land as one run
    task automatic send_check_run(input logic [7:0] flip, input int at);
        logic [7:0] crc_bytes [EMIT_LEN];
        while (sb.rx_count != 3'd0)
            send_word(OP_CHECK, 8'($urandom));
        for (int k = 0; k < EMIT_LEN; k++)
            crc_bytes[k] = sb.crc_byte(k);
        crc_bytes[at] ^= flip;
        for (int k = 0; k < EMIT_LEN; k++)
            send_word(OP_CHECK, crc_bytes[k]);
    endtask

    task automatic random_phase(input int n);
        int target;
        int pick;
        logic [7:0] flip;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_data_burst($urandom_range(1, 10));
                flip = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_check_run(flip, $urandom_range(0, EMIT_LEN - 1));
            end else if (pick < 70) begin
                send_data_burst($urandom_range(0, 10));
                send_word(OP_EMIT, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_DATA;
        in_if.data_byte = 8'h00;
        out_if.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_left = 0;
        items_sent = 0;
        cycle_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_DATA, 8'hFF);
        send_word(OP_DATA, 8'h00);
        send_word(OP_DATA, 8'hA5);
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_EMIT, 8'h00);
        send_word(OP_DATA, 8'h80);
        send_word(OP_DATA, 8'h01);
        // lane 3 damaged: ignored in one-line mode
        send_check_run(8'h80, 3);
        write_mode(1'b1);
        send_word(OP_DATA, 8'h0F);
        send_check_run(8'h08, 5);

        write_mode(1'b0);
        hold_left <= LONG_HOLD;
        random_phase(55);

        write_mode(1'b1);
        send_idle = 84;
        random_phase(55);

        write_mode(1'b0);
        send_idle = 0;
        recv_stall = 84;
        random_phase(55);

        write_mode(1'b1);
        send_idle = 20;
        recv_stall = 20;
        random_phase(55);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sd_dat4_crc16_engine_core.f
src/sd4c_pkg.sv
src/sd4c_if.sv
src/sd4c_lane_crc.sv
src/sd4c_out_seq.sv
src/sd_dat4_crc16_engine_core.sv
dv/sd_dat4_crc16_engine_core_tb.sv
